// File: src/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared constants, token types and helpers for the token scanner.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int POSITION_BITS = 16;
    localparam int TOK_POS_W     = 16;
    localparam int KIND_W        = 4;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // scan modes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_VAR    = 2'd2;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_EQUALS = 4'd0;
    localparam logic [KIND_W-1:0] KIND_COLON  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd3;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd5;
    localparam logic [KIND_W-1:0] KIND_STRING = 4'd6;
    localparam logic [KIND_W-1:0] KIND_VAR    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END    = 4'd8;
    localparam logic [KIND_W-1:0] KIND_UNTERM = 4'd9;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TOK_POS_W-1:0] start;
        logic [TOK_POS_W-1:0] stop;
        logic                 last;
    } token_t;

    // one queue entry: every token caused by one byte
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } tok_pair_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic token_t make_tok(
        input logic [KIND_W-1:0]        kind,
        input logic [POSITION_BITS-1:0] s,
        input logic [POSITION_BITS-1:0] e
    );
        token_t t;
        t.kind  = kind;
        t.start = TOK_POS_W'(s);
        t.stop  = TOK_POS_W'(e);
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

// File: src/tsc_byte_if.sv
// ----------------------------------------------------------------------------
// tsc_byte_if
// Text byte channel: valid/ready handshake with one byte of source text.
// ----------------------------------------------------------------------------
interface tsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

// File: src/tsc_token_if.sv
// ----------------------------------------------------------------------------
// tsc_token_if
// Token channel: valid/ready handshake with one token word.
// ----------------------------------------------------------------------------
interface tsc_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_end;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_end, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_end, input last_of_run, output ready);
endinterface

// File: src/tsc_front.sv
// ----------------------------------------------------------------------------
// tsc_front
// Scan state machine: takes a byte, updates mode and position, and pushes
// the one or two tokens that byte closes into the queue.
// ----------------------------------------------------------------------------
module tsc_front
(
    input  logic               clk,
    input  logic               rst_n,
    tsc_byte_if.sink           text,
    input  tsc_pkg::q_stat_t   q_stat,
    output logic               push,
    output tsc_pkg::tok_pair_t push_data
);
    import tsc_pkg::*;

    logic [1:0]               mode_reg, mode_next;
    logic [POSITION_BITS-1:0] ots_reg, ots_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic                     accept;
    logic [7:0]               b;
    logic [POSITION_BITS-1:0] pos_inc;
    logic                     is_space;
    logic                     is_brk;
    logic                     fall;
    logic [1:0]               n;
    token_t                   t0, t1, ts;
    logic [KIND_W-1:0]        sk;
    logic                     sk_hit;

    assign text.ready = !q_stat.full;
    assign accept     = text.valid && text.ready;
    assign b          = text.text_byte;
    assign pos_inc    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        is_space = b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
        is_brk   = b inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};
        sk_hit   = 1'b1;
        case (b)
            CH_EQUALS: sk = KIND_EQUALS;
            CH_COLON:  sk = KIND_COLON;
            CH_LPAREN: sk = KIND_LPAREN;
            CH_RPAREN: sk = KIND_RPAREN;
            CH_LBRACE: sk = KIND_LBRACE;
            CH_RBRACE: sk = KIND_RBRACE;
            default:
            begin
                sk     = KIND_END;
                sk_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        ots_next  = ots_reg;
        pos_next  = pos_inc;
        n         = 2'd0;
        t0        = make_tok(KIND_END, pos_reg, pos_reg);
        t1        = t0;
        ts        = t0;
        fall      = 1'b0;

        // open token first
        case (mode_reg)
            MODE_STRING:
            begin
                if (b == CH_NUL)
                begin
                    t0   = make_tok(KIND_UNTERM, ots_reg, pos_reg);
                    n    = 2'd1;
                    fall = 1'b1;
                end
                else if (b == CH_QUOTE)
                begin
                    t0        = make_tok(KIND_STRING, ots_reg, pos_inc);
                    n         = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_VAR:
            begin
                if (b == CH_NUL || is_space || is_brk)
                begin
                    t0        = make_tok(KIND_VAR, ots_reg, pos_reg);
                    n         = 2'd1;
                    mode_next = MODE_IDLE;
                    fall      = 1'b1;
                end
            end
            default:
                fall = 1'b1;
        endcase

        // between tokens
        if (fall)
        begin
            mode_next = MODE_IDLE;
            if (b == CH_NUL)
            begin
                ts       = make_tok(KIND_END, pos_reg, pos_reg);
                ots_next = '0;
                pos_next = '0;
            end
            else if (sk_hit)
                ts = make_tok(sk, pos_reg, pos_inc);
            else if (!is_space)
            begin
                mode_next = (b == CH_QUOTE) ? MODE_STRING : MODE_VAR;
                ots_next  = pos_reg;
            end

            if (b == CH_NUL || sk_hit)
            begin
                if (n == 2'd0)
                    t0 = ts;
                else
                    t1 = ts;
                n = n + 2'd1;
            end
        end
    end

    always_comb
    begin
        push_data.two  = (n == 2'd2);
        push_data.tok0 = t0;
        push_data.tok1 = t1;
        push_data.tok0.last = (n == 2'd1);
        push_data.tok1.last = 1'b1;
    end

    assign push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            ots_reg  <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            ots_reg  <= ots_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// File: src/tsc_queue.sv
// ----------------------------------------------------------------------------
// tsc_queue
// Small FIFO of token pairs between the scanner and the output stage.
// ----------------------------------------------------------------------------
module tsc_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tsc_pkg::tok_pair_t push_data,
    input  logic               pop,
    output tsc_pkg::tok_pair_t head,
    output tsc_pkg::q_stat_t   q_stat
);
    import tsc_pkg::*;

    tok_pair_t         entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head         = entries_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/tsc_back.sv
// ----------------------------------------------------------------------------
// tsc_back
// Output stage: unpacks queue entries into single token words and holds
// each in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tsc_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsc_pkg::tok_pair_t head,
    input  tsc_pkg::q_stat_t   q_stat,
    output logic               pop,
    tsc_token_if.source        token
);
    import tsc_pkg::*;

    logic   out_valid_reg, out_valid_next;
    token_t out_tok_reg;
    logic   half_reg, half_next;
    logic   load;
    token_t sel_tok;

    assign load    = !q_stat.empty && (!out_valid_reg || token.ready);
    assign sel_tok = half_reg ? head.tok1 : head.tok0;

    // a two-token entry stays at the head until its second word is loaded
    always_comb
    begin
        pop       = 1'b0;
        half_next = half_reg;
        if (load)
        begin
            if (head.two && !half_reg)
                half_next = 1'b1;
            else
            begin
                half_next = 1'b0;
                pop       = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (token.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_tok_reg <= sel_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    assign token.valid       = out_valid_reg;
    assign token.token_kind  = out_tok_reg.kind;
    assign token.token_start = out_tok_reg.start;
    assign token.token_end   = out_tok_reg.stop;
    assign token.last_of_run = out_tok_reg.last;

endmodule

// File: src/token_scanner_core.sv
// ----------------------------------------------------------------------------
// token_scanner_core
// Streaming lexical scanner: one text byte in, token words out.
// ----------------------------------------------------------------------------
// Channels: text (sink) carries one source byte per word; byte 0 ends the
// text, closes any open token, emits an end token and restarts the offset
// count at zero. token (source) carries kind, start, end (exclusive) and
// last_of_run, which marks the final token caused by one byte.
// A byte is taken every cycle while the four-entry token queue has room;
// bytes that make no token (whitespace, inside a string or name) never
// wait on the output side beyond that. The scanner writes each token into
// the queue; the queue head then loads into the output register.
// The output register issues one word per cycle while the receiver keeps
// taking, so a byte with two tokens needs two output words; sustained rate
// is one byte per cycle while tokens average no more than one per byte.
// When the receiver stalls, the output word holds and the queue fills;
// once full, text.ready drops until the head entry has gone out to the
// output register (one word taken, or two for a byte with two tokens).
// Reset clears the scan mode, offset and queue; no tokens are pending.
// ----------------------------------------------------------------------------
module token_scanner_core
(
    input  logic        clk,
    input  logic        rst_n,
    tsc_byte_if.sink    text,
    tsc_token_if.source token
);
    import tsc_pkg::*;

    logic      push;
    logic      pop;
    tok_pair_t push_data;
    tok_pair_t head;
    q_stat_t   q_stat;

    tsc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    tsc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    tsc_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .token  (token)
    );

endmodule
